// ===== hw/rtl/trimmed_mean_offset_calibration_top_macros.svh =====
// Assertion helpers for the trimmed mean calibration block.
`ifndef TRIMMED_MEAN_OFFSET_CALIBRATION_TOP_MACROS_SVH
`define TRIMMED_MEAN_OFFSET_CALIBRATION_TOP_MACROS_SVH
`ifndef SYNTH
`define TMOC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define TMOC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TMOC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TMOC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/tmoc_pkg.sv =====
package tmoc_pkg;

   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int CHANNELS_DEF    = 4;
   localparam int SAMPLE_BITS_DEF = 12;

   localparam int SET_W       = 11;
   localparam int TRIM_W      = 9;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 1;
   localparam int CHAN_W      = 2;
   localparam int NOISE_W     = 16;
   localparam int IN_CHANNELS = 4;
   localparam int PRE_SHIFT   = 8;
   localparam int NOISE_MAX   = 65535;

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIM_COUNT   = 1'd1;

   localparam logic [SET_W-1:0]  SAMPLE_COUNT_RST = 11'd1000;
   localparam logic [TRIM_W-1:0] TRIM_COUNT_RST   = 9'd100;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int min_int(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   // Width of a count that holds any effective sample count.
   function automatic int count_width(input int max_samples);
      return max_int(SET_W, $clog2(max_samples + 1));
   endfunction

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN,
      ST_FINISH,
      ST_ERROR
   } tmoc_state_type;

   typedef enum logic [2:0] {
      MS_IDLE,
      MS_SQUARE,
      MS_MUL,
      MS_SUB,
      MS_DIV_MEAN,
      MS_SQRT,
      MS_DIV_DEV
   } tmoc_math_state_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } tmoc_chain_ctl_type;

   typedef struct packed {
      logic vld;
      logic keep;
      logic first;
      logic last;
   } tmoc_feed_type;

endpackage

// ===== hw/rtl/tmoc_cell.sv =====
module tmoc_cell #(
   parameter int VAL_W = tmoc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tmoc_pkg::tmoc_chain_ctl_type ctl,
   input  logic                        in_vld,
   input  logic [VAL_W-1:0]            in_val,
   input  logic                        nb_vld,
   input  logic [VAL_W-1:0]            nb_val,
   output logic                        pass_vld,
   output logic [VAL_W-1:0]            pass_val,
   output logic                        hold_vld,
   output logic [VAL_W-1:0]            hold_val
);

   logic             hold_vld_ff, hold_vld_in;
   logic [VAL_W-1:0] hold_val_ff, hold_val_in;
   logic             pass_vld_ff, pass_vld_in;
   logic [VAL_W-1:0] pass_val_ff, pass_val_in;

   // The cell keeps the smaller of its value and the arriving one and hands
   // the larger one on; in shift mode the row moves toward the head.
   always_comb begin
      hold_vld_in = hold_vld_ff;
      hold_val_in = hold_val_ff;
      pass_vld_in = 1'b0;
      pass_val_in = pass_val_ff;
      if (ctl.clear) begin
         hold_vld_in = 1'b0;
      end else if (ctl.shift) begin
         hold_vld_in = nb_vld;
         hold_val_in = nb_val;
      end else if (in_vld) begin
         if (!hold_vld_ff) begin
            hold_vld_in = 1'b1;
            hold_val_in = in_val;
         end else if (in_val < hold_val_ff) begin
            hold_val_in = in_val;
            pass_vld_in = 1'b1;
            pass_val_in = hold_val_ff;
         end else begin
            pass_vld_in = 1'b1;
            pass_val_in = in_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         pass_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         pass_vld_ff <= pass_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_val_ff <= hold_val_in;
      pass_val_ff <= pass_val_in;
   end

   assign pass_vld = pass_vld_ff;
   assign pass_val = pass_val_ff;
   assign hold_vld = hold_vld_ff;
   assign hold_val = hold_val_ff;

endmodule

// ===== hw/rtl/tmoc_chain.sv =====
module tmoc_chain #(
   parameter int DEPTH = tmoc_pkg::MAX_SAMPLES_DEF,
   parameter int VAL_W = tmoc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tmoc_pkg::tmoc_chain_ctl_type ctl,
   input  logic                        in_vld,
   input  logic [VAL_W-1:0]            in_val,
   output logic                        head_vld,
   output logic [VAL_W-1:0]            head_val
);

   logic             pvld [0:DEPTH];
   logic [VAL_W-1:0] pval [0:DEPTH];
   logic             hvld [0:DEPTH];
   logic [VAL_W-1:0] hval [0:DEPTH];

   assign pvld[0] = in_vld;
   assign pval[0] = in_val;
   // Past the tail the row reads as empty.
   assign hvld[DEPTH] = 1'b0;
   assign hval[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      tmoc_cell #(
         .VAL_W(VAL_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .in_vld  (pvld[i]),
         .in_val  (pval[i]),
         .nb_vld  (hvld[i+1]),
         .nb_val  (hval[i+1]),
         .pass_vld(pvld[i+1]),
         .pass_val(pval[i+1]),
         .hold_vld(hvld[i]),
         .hold_val(hval[i])
      );
   end

   assign head_vld = hvld[0];
   assign head_val = hval[0];

endmodule

// ===== hw/rtl/tmoc_math.sv =====
module tmoc_math #(
   parameter int MAX_SAMPLES = tmoc_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = tmoc_pkg::SAMPLE_BITS_DEF,
   localparam int N_W        = tmoc_pkg::count_width(MAX_SAMPLES)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tmoc_pkg::tmoc_feed_type        feed,
   input  logic [SAMPLE_BITS-1:0]         feed_val,
   input  logic [N_W-1:0]                 m,
   output logic                           done,
   output logic [SAMPLE_BITS-1:0]         offset,
   output logic [tmoc_pkg::NOISE_W-1:0]   noise
);

   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int SQ0_W  = 2 * SAMPLE_BITS;
   localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
   localparam int SQ_W   = SQ0_W + ADDR_W;
   localparam int SS_W   = 2 * SUM_W;
   localparam int D_W    = N_W + SQ_W;
   localparam int RT_W   = (D_W + tmoc_pkg::PRE_SHIFT + 1) / 2;
   localparam int RAD_W  = 2 * RT_W;
   localparam int SR_W   = RT_W + 3;
   localparam int DIV_W  = tmoc_pkg::max_int(SUM_W, RT_W);
   localparam int STEP_W = $clog2(tmoc_pkg::max_int(DIV_W, tmoc_pkg::max_int(RT_W, N_W)) + 1);

   tmoc_pkg::tmoc_feed_type  f1_ff, f2_ff;
   logic [SAMPLE_BITS-1:0]   v1_ff, v2_ff;
   logic [SQ0_W-1:0]         sq2_ff;
   logic [SQ0_W-1:0]         v1_ext;

   tmoc_pkg::tmoc_math_state_type ms_ff, ms_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  s_ff, s_in;
   logic [SQ_W-1:0]   q_ff, q_in;
   logic [SS_W-1:0]   ss_ff, ss_in;
   logic [SS_W-1:0]   s_ext;
   logic [D_W-1:0]    acc_ff, acc_in;
   logic [D_W-1:0]    qsh_ff, qsh_in;
   logic [N_W-1:0]    msh_ff, msh_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [N_W-1:0]    rem_ff, rem_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [RT_W-1:0]   root_ff, root_in;
   logic [SR_W-1:0]   srem_ff, srem_in;
   logic [SAMPLE_BITS-1:0]       offset_ff, offset_in;
   logic [tmoc_pkg::NOISE_W-1:0] noise_ff, noise_in;
   logic              done_ff, done_in;

   logic [N_W:0]      div_r;
   logic              div_ge;
   logic [N_W-1:0]    div_rem_nxt;
   logic [DIV_W-1:0]  div_q_nxt;
   logic [SR_W-1:0]   sq_t, sq_trial;
   logic              sq_ge;
   logic [RT_W-1:0]   root_nxt;

   assign v1_ext = SQ0_W'(v1_ff);
   assign s_ext  = SS_W'(s_ff);

   // Feed pipeline: mask dropped values, then square.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff <= '0;
         f2_ff <= '0;
      end else begin
         f1_ff <= feed;
         f2_ff <= f1_ff;
      end
   end

   always_ff @(posedge clock) begin
      v1_ff  <= feed.keep ? feed_val : '0;
      v2_ff  <= v1_ff;
      sq2_ff <= v1_ext * v1_ext;
   end

   // One restoring division step by m.
   always_comb begin
      div_r       = {rem_ff, dvd_ff[DIV_W-1]};
      div_ge      = (div_r >= {1'b0, m});
      div_rem_nxt = div_ge ? N_W'(div_r - {1'b0, m}) : N_W'(div_r);
      div_q_nxt   = {dvd_ff[DIV_W-2:0], div_ge};
   end

   // One bit of the square root per step.
   always_comb begin
      sq_t     = {srem_ff[RT_W:0], rad_ff[RAD_W-1 -: 2]};
      sq_trial = SR_W'({root_ff, 2'b01});
      sq_ge    = (sq_t >= sq_trial);
      root_nxt = {root_ff[RT_W-2:0], sq_ge};
   end

   always_comb begin
      ms_in     = ms_ff;
      step_in   = step_ff;
      s_in      = s_ff;
      q_in      = q_ff;
      ss_in     = ss_ff;
      acc_in    = acc_ff;
      qsh_in    = qsh_ff;
      msh_in    = msh_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      offset_in = offset_ff;
      noise_in  = noise_ff;
      done_in   = 1'b0;
      if (f2_ff.vld) begin
         s_in = f2_ff.first ? SUM_W'(v2_ff) : s_ff + SUM_W'(v2_ff);
         q_in = f2_ff.first ? SQ_W'(sq2_ff) : q_ff + SQ_W'(sq2_ff);
      end
      unique case (ms_ff)
         tmoc_pkg::MS_IDLE: begin
            if (f2_ff.vld && f2_ff.last) begin
               ms_in = tmoc_pkg::MS_SQUARE;
            end
         end
         tmoc_pkg::MS_SQUARE: begin
            ss_in   = s_ext * s_ext;
            acc_in  = '0;
            qsh_in  = D_W'(q_ff);
            msh_in  = m;
            step_in = '0;
            ms_in   = tmoc_pkg::MS_MUL;
         end
         tmoc_pkg::MS_MUL: begin
            if (msh_ff[0]) begin
               acc_in = acc_ff + qsh_ff;
            end
            qsh_in  = qsh_ff << 1;
            msh_in  = msh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(N_W - 1)) begin
               step_in = '0;
               ms_in   = tmoc_pkg::MS_SUB;
            end
         end
         tmoc_pkg::MS_SUB: begin
            acc_in  = acc_ff - D_W'(ss_ff);
            dvd_in  = DIV_W'(s_ff);
            rem_in  = '0;
            step_in = '0;
            ms_in   = tmoc_pkg::MS_DIV_MEAN;
         end
         tmoc_pkg::MS_DIV_MEAN: begin
            rem_in  = div_rem_nxt;
            dvd_in  = div_q_nxt;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               offset_in = div_q_nxt[SAMPLE_BITS-1:0];
               rad_in    = RAD_W'({acc_ff, {tmoc_pkg::PRE_SHIFT{1'b0}}});
               root_in   = '0;
               srem_in   = '0;
               step_in   = '0;
               ms_in     = tmoc_pkg::MS_SQRT;
            end
         end
         tmoc_pkg::MS_SQRT: begin
            srem_in = sq_ge ? sq_t - sq_trial : sq_t;
            root_in = root_nxt;
            rad_in  = rad_ff << 2;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(RT_W - 1)) begin
               dvd_in  = DIV_W'(root_nxt);
               rem_in  = '0;
               step_in = '0;
               ms_in   = tmoc_pkg::MS_DIV_DEV;
            end
         end
         tmoc_pkg::MS_DIV_DEV: begin
            rem_in  = div_rem_nxt;
            dvd_in  = div_q_nxt;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               noise_in = (div_q_nxt > DIV_W'(tmoc_pkg::NOISE_MAX)) ?
                          '1 : div_q_nxt[tmoc_pkg::NOISE_W-1:0];
               done_in  = 1'b1;
               step_in  = '0;
               ms_in    = tmoc_pkg::MS_IDLE;
            end
         end
         default: begin
            ms_in = tmoc_pkg::MS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff   <= tmoc_pkg::MS_IDLE;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ms_ff   <= ms_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      q_ff      <= q_in;
      ss_ff     <= ss_in;
      acc_ff    <= acc_in;
      qsh_ff    <= qsh_in;
      msh_ff    <= msh_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      srem_ff   <= srem_in;
      offset_ff <= offset_in;
      noise_ff  <= noise_in;
   end

   assign done   = done_ff;
   assign offset = offset_ff;
   assign noise  = noise_ff;

endmodule

// ===== hw/rtl/trimmed_mean_offset_calibration_top.sv =====
// Trimmed mean zero-offset calibration for a group of ADC current channels.
// A sample beat (one value per channel) is taken when start is high and busy
// is low; req_abort on that beat drops the collection so far and stores
// nothing. Collection takes one beat per cycle and only writes the sample
// memory. After sample_count beats busy rises and each channel in turn is
// read out of memory into a row of sorting cells, left to settle, shifted
// out in order through the sum and square-sum accumulators and finished by
// a sequential unit: multiply (count width steps), mean division, square
// root and deviation division, one bit per cycle each. When too few samples
// remain after trimming, the error results, one per channel, follow on
// consecutive cycles. Each result shows for one cycle with rsp_strobe; the
// receiver cannot stall, so nothing waits. The CSR port must be written only
// while busy is low; the block itself does not enforce this. Reset restores
// the register defaults, clears the beat count and the row; the sample
// memory is not cleared.
`include "trimmed_mean_offset_calibration_top_macros.svh"

module trimmed_mean_offset_calibration_top #(
   parameter int MAX_SAMPLES = tmoc_pkg::MAX_SAMPLES_DEF,
   parameter int CHANNELS    = tmoc_pkg::CHANNELS_DEF,
   parameter int SAMPLE_BITS = tmoc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [SAMPLE_BITS-1:0]          req_sample_ch0,
   input  logic [SAMPLE_BITS-1:0]          req_sample_ch1,
   input  logic [SAMPLE_BITS-1:0]          req_sample_ch2,
   input  logic [SAMPLE_BITS-1:0]          req_sample_ch3,
   input  logic                            req_abort,
   output logic                            rsp_strobe,
   output logic [tmoc_pkg::CHAN_W-1:0]     rsp_channel,
   output logic [SAMPLE_BITS-1:0]          rsp_zero_offset,
   output logic [tmoc_pkg::NOISE_W-1:0]    rsp_noise_q4,
   output logic                            rsp_trim_error,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [tmoc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmoc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W  = $clog2(MAX_SAMPLES);
   localparam int N_W     = tmoc_pkg::count_width(MAX_SAMPLES);
   localparam int CH_W    = tmoc_pkg::max_int(1, $clog2(CHANNELS));
   localparam int MEM_W   = CHANNELS * SAMPLE_BITS;
   localparam int LIVE_CH = tmoc_pkg::min_int(CHANNELS, tmoc_pkg::IN_CHANNELS);

   logic [tmoc_pkg::SET_W-1:0]  sample_count_ff;
   logic [tmoc_pkg::TRIM_W-1:0] trim_count_ff;

   tmoc_pkg::tmoc_state_type state_ff, state_in;
   logic [tmoc_pkg::SET_W-1:0] set_cnt_ff, set_cnt_in, set_next;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [N_W-1:0]   cnt_ff, cnt_in;
   logic             rd_vld_ff;
   logic             rd_issue;
   logic             mem_we;

   logic [MEM_W-1:0]  mem [0:MAX_SAMPLES-1];
   logic [MEM_W-1:0]  wdata;
   logic [MEM_W-1:0]  rdata_ff;
   logic [ADDR_W-1:0] waddr;
   logic [SAMPLE_BITS-1:0] smp [0:tmoc_pkg::IN_CHANNELS-1];

   logic [N_W-1:0] n_eff, sc_ext, set_ext, two_t, trim_ext, m_val, upper;
   logic           trim_err, set_done, ch_last;

   tmoc_pkg::tmoc_chain_ctl_type chain_ctl;
   tmoc_pkg::tmoc_feed_type      feed;
   logic                   head_vld;
   logic [SAMPLE_BITS-1:0] head_val;

   logic                         math_done;
   logic [SAMPLE_BITS-1:0]       math_offset;
   logic [tmoc_pkg::NOISE_W-1:0] math_noise;

   logic                         rsp_vld_ff, rsp_vld_in;
   logic [tmoc_pkg::CHAN_W-1:0]  rsp_chan_ff, rsp_chan_in;
   logic [SAMPLE_BITS-1:0]       rsp_offs_ff, rsp_offs_in;
   logic [tmoc_pkg::NOISE_W-1:0] rsp_noise_ff, rsp_noise_in;
   logic                         rsp_err_ff, rsp_err_in;
   logic                         rsp_last_ff, rsp_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= tmoc_pkg::SAMPLE_COUNT_RST;
         trim_count_ff   <= tmoc_pkg::TRIM_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            tmoc_pkg::REG_SAMPLE_COUNT: sample_count_ff <= csr_wdata;
            tmoc_pkg::REG_TRIM_COUNT:   trim_count_ff <= csr_wdata[tmoc_pkg::TRIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective count, trim bounds and the write slot of the current beat.
   always_comb begin
      sc_ext = N_W'(sample_count_ff);
      if (sample_count_ff == '0) begin
         n_eff = N_W'(1);
      end else if (sc_ext > N_W'(MAX_SAMPLES)) begin
         n_eff = N_W'(MAX_SAMPLES);
      end else begin
         n_eff = sc_ext;
      end
      trim_ext = N_W'(trim_count_ff);
      two_t    = N_W'({trim_count_ff, 1'b0});
      trim_err = (two_t >= n_eff);
      m_val    = n_eff - two_t;
      upper    = n_eff - trim_ext;
      set_ext  = N_W'(set_cnt_ff);
      set_next = set_cnt_ff + 1'b1;
      set_done = (N_W'(set_next) >= n_eff);
      if (set_ext >= N_W'(MAX_SAMPLES)) begin
         waddr = ADDR_W'(MAX_SAMPLES - 1);
      end else begin
         waddr = set_ext[ADDR_W-1:0];
      end
      ch_last = (ch_ff == CH_W'(CHANNELS - 1));
   end

   assign smp[0] = req_sample_ch0;
   assign smp[1] = req_sample_ch1;
   assign smp[2] = req_sample_ch2;
   assign smp[3] = req_sample_ch3;

   // Channels past the four inputs store zero.
   always_comb begin
      wdata = '0;
      for (int c = 0; c < LIVE_CH; c++) begin
         wdata[c*SAMPLE_BITS +: SAMPLE_BITS] = smp[c];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[cnt_ff[ADDR_W-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      set_cnt_in   = set_cnt_ff;
      ch_in        = ch_ff;
      cnt_in       = cnt_ff;
      mem_we       = 1'b0;
      rd_issue     = 1'b0;
      chain_ctl    = '0;
      feed         = '0;
      rsp_vld_in   = 1'b0;
      rsp_chan_in  = rsp_chan_ff;
      rsp_offs_in  = rsp_offs_ff;
      rsp_noise_in = rsp_noise_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         tmoc_pkg::ST_COLLECT: begin
            if (start) begin
               if (req_abort) begin
                  set_cnt_in = '0;
               end else begin
                  mem_we = 1'b1;
                  if (set_done) begin
                     set_cnt_in      = '0;
                     ch_in           = '0;
                     cnt_in          = '0;
                     chain_ctl.clear = 1'b1;
                     state_in = trim_err ? tmoc_pkg::ST_ERROR : tmoc_pkg::ST_LOAD;
                  end else begin
                     set_cnt_in = set_next;
                  end
               end
            end
         end
         tmoc_pkg::ST_LOAD: begin
            rd_issue = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == n_eff - 1'b1) begin
               cnt_in   = '0;
               state_in = tmoc_pkg::ST_SETTLE;
            end
         end
         tmoc_pkg::ST_SETTLE: begin
            // The last displaced value may still be walking down the row.
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == n_eff) begin
               cnt_in   = '0;
               state_in = tmoc_pkg::ST_DRAIN;
            end
         end
         tmoc_pkg::ST_DRAIN: begin
            chain_ctl.shift = 1'b1;
            feed.vld        = 1'b1;
            feed.keep       = (cnt_ff >= trim_ext) && (cnt_ff < upper);
            feed.first      = (cnt_ff == '0);
            feed.last       = (cnt_ff == n_eff - 1'b1);
            cnt_in          = cnt_ff + 1'b1;
            if (feed.last) begin
               cnt_in   = '0;
               state_in = tmoc_pkg::ST_FINISH;
            end
         end
         tmoc_pkg::ST_FINISH: begin
            if (math_done) begin
               rsp_vld_in   = 1'b1;
               rsp_chan_in  = tmoc_pkg::CHAN_W'(ch_ff);
               rsp_offs_in  = math_offset;
               rsp_noise_in = math_noise;
               rsp_err_in   = 1'b0;
               rsp_last_in  = ch_last;
               if (ch_last) begin
                  state_in = tmoc_pkg::ST_COLLECT;
               end else begin
                  ch_in           = ch_ff + 1'b1;
                  chain_ctl.clear = 1'b1;
                  state_in        = tmoc_pkg::ST_LOAD;
               end
            end
         end
         tmoc_pkg::ST_ERROR: begin
            rsp_vld_in   = 1'b1;
            rsp_chan_in  = tmoc_pkg::CHAN_W'(ch_ff);
            rsp_offs_in  = '0;
            rsp_noise_in = '0;
            rsp_err_in   = 1'b1;
            rsp_last_in  = ch_last;
            if (ch_last) begin
               state_in = tmoc_pkg::ST_COLLECT;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         default: begin
            state_in = tmoc_pkg::ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tmoc_pkg::ST_COLLECT;
         set_cnt_ff <= '0;
         ch_ff      <= '0;
         cnt_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         set_cnt_ff <= set_cnt_in;
         ch_ff      <= ch_in;
         cnt_ff     <= cnt_in;
         rd_vld_ff  <= rd_issue;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_chan_ff  <= rsp_chan_in;
      rsp_offs_ff  <= rsp_offs_in;
      rsp_noise_ff <= rsp_noise_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   tmoc_chain #(
      .DEPTH(MAX_SAMPLES),
      .VAL_W(SAMPLE_BITS)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctl     (chain_ctl),
      .in_vld  (rd_vld_ff),
      .in_val  (rdata_ff[ch_ff*SAMPLE_BITS +: SAMPLE_BITS]),
      .head_vld(head_vld),
      .head_val(head_val)
   );

   tmoc_math #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_math (
      .clock   (clock),
      .reset   (reset),
      .feed    (feed),
      .feed_val(head_val),
      .m       (m_val),
      .done    (math_done),
      .offset  (math_offset),
      .noise   (math_noise)
   );

   assign busy            = (state_ff != tmoc_pkg::ST_COLLECT);
   assign rsp_strobe      = rsp_vld_ff;
   assign rsp_channel     = rsp_chan_ff;
   assign rsp_zero_offset = rsp_offs_ff;
   assign rsp_noise_q4    = rsp_noise_ff;
   assign rsp_trim_error  = rsp_err_ff;
   assign rsp_last        = rsp_last_ff;

   `TMOC_ASSERT_IMPL(a_drain_head_full, clock, reset, state_ff == tmoc_pkg::ST_DRAIN, head_vld)
   `TMOC_ASSERT_IMPL(a_done_in_finish, clock, reset, math_done, state_ff == tmoc_pkg::ST_FINISH)
   `TMOC_ASSERT_NEXT(a_last_then_idle, clock, reset, rsp_vld_ff && rsp_last_ff, !rsp_vld_ff)

endmodule
